[sv/lsr_pkg.sv]
// lsr_pkg: shared types and constants of the line span rasteriser
// holds the request and span payload structs and the divider handshake structs
// no dependencies
package lsr_pkg;

    // coordinate width of every column and row field
    localparam int COORD_WIDTH = 10;
    localparam int COLOR_WIDTH = 16;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [COLOR_WIDTH-1:0] color_t;

    // request codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // one request on the input channel
    typedef struct packed {
        logic   cmd;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } lsr_in_t;

    // one span on the result channel
    typedef struct packed {
        coord_t column_x;
        coord_t span_low;
        coord_t span_high;
        color_t span_color;
        logic   last_span;
    } lsr_out_t;

    // divider start request
    typedef struct packed {
        logic   start;
        coord_t dividend;
        coord_t divisor;
    } lsr_div_req_t;

    // divider result
    typedef struct packed {
        logic   done;
        coord_t quotient;
        coord_t remainder;
    } lsr_div_rsp_t;

endpackage

[sv/lsr_div.sv]
// lsr_div: restoring divider, one quotient bit per cycle
// produces quotient and remainder of |dy| / dx for the slope
// depends on lsr_pkg
module lsr_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lsr_pkg::lsr_div_req_t req,
    output lsr_pkg::lsr_div_rsp_t rsp
);

    localparam int W     = lsr_pkg::COORD_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [W-1:0]     rem_reg,  rem_next;
    logic [W-1:0]     quo_reg,  quo_next;
    logic [W-1:0]     dvs_reg,  dvs_next;

    logic [W:0]       partial;
    logic [W:0]       diff;
    logic             fits;

    // one restoring step: bring down the next dividend bit and try the divisor
    always_comb begin
        partial = {rem_reg, quo_reg[W-1]};
        diff    = partial - {1'b0, dvs_reg};
        fits    = partial >= {1'b0, dvs_reg};
    end

    // sequencing of the iterations
    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(W - 1);
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
        end else if (run_reg) begin
            rem_next = fits ? diff[W-1:0] : partial[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

[sv/line_span_rasterizer.sv]
// line_span_rasterizer: top level, request sequencer, span stepping and output register
// instantiates lsr_div; depends on lsr_pkg
//
// Draws a straight line as vertical pixel spans, at most one span per request. A load
// request orders the endpoints, starts the bit-serial divider for the slope
// quotient and remainder, and returns the first span; the next request can be
// taken only once the divider, producing one quotient bit a cycle, has finished
// and the span has gone to the output register. A vertical line (equal columns)
// skips the divider and goes straight to handing over its single span. Each advance
// request does one error-accumulator add-and-compare step at acceptance and then
// hands the span to the output register once that is free. An advance with no line in
// progress gives no span and leaves the block ready. The span waits in the output
// register while the next request is accepted.
module line_span_rasterizer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lsr_pkg::lsr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output lsr_pkg::lsr_out_t m_data
);

    localparam int W = lsr_pkg::COORD_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic                line_busy_reg, line_busy_next;
    lsr_pkg::coord_t     column_now_reg, column_now_next;
    lsr_pkg::coord_t     column_last_reg, column_last_next;
    lsr_pkg::coord_t     row_previous_reg, row_previous_next;
    lsr_pkg::coord_t     row_base_reg, row_base_next;
    lsr_pkg::coord_t     step_quotient_reg, step_quotient_next;
    lsr_pkg::coord_t     step_remainder_reg, step_remainder_next;
    logic [W:0]          error_acc_reg, error_acc_next;
    lsr_pkg::coord_t     column_span_reg, column_span_next;
    logic                going_down_reg, going_down_next;
    lsr_pkg::color_t     held_color_reg, held_color_next;
    lsr_pkg::lsr_out_t   span_reg, span_next;
    logic                m_valid_reg, m_valid_next;
    lsr_pkg::lsr_out_t   m_data_reg, m_data_next;

    lsr_pkg::lsr_div_req_t div_req;
    lsr_pkg::lsr_div_rsp_t div_rsp;

    logic            accept;
    logic            out_free;

    // load: endpoint ordering and deltas
    logic            swap;
    lsr_pkg::coord_t ord_x0, ord_y0, ord_x1, ord_y1;
    lsr_pkg::coord_t load_dx, load_dy;
    logic            load_down;
    lsr_pkg::coord_t vert_lo, vert_hi;

    // advance: one accumulator step
    lsr_pkg::coord_t col_inc;
    logic [W:0]      acc_sum;
    logic            acc_wrap;
    logic [W:0]      acc_new;
    lsr_pkg::coord_t row_step;
    lsr_pkg::coord_t base_new;
    lsr_pkg::coord_t target;
    logic            at_last;
    lsr_pkg::coord_t adv_lo, adv_hi;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // endpoint ordering so the walk runs toward larger columns
    always_comb begin
        swap      = s_data.start_x > s_data.end_x;
        ord_x0    = swap ? s_data.end_x   : s_data.start_x;
        ord_y0    = swap ? s_data.end_y   : s_data.start_y;
        ord_x1    = swap ? s_data.start_x : s_data.end_x;
        ord_y1    = swap ? s_data.start_y : s_data.end_y;
        load_dx   = ord_x1 - ord_x0;
        load_down = ord_y1 < ord_y0;
        load_dy   = load_down ? (ord_y0 - ord_y1) : (ord_y1 - ord_y0);
        vert_lo   = (s_data.start_y < s_data.end_y) ? s_data.start_y : s_data.end_y;
        vert_hi   = (s_data.start_y < s_data.end_y) ? s_data.end_y : s_data.start_y;
    end

    // next column: add remainder, fold back past dx, move the row base
    always_comb begin
        col_inc  = column_now_reg + 1'b1;
        acc_sum  = error_acc_reg + {1'b0, step_remainder_reg};
        acc_wrap = acc_sum >= {1'b0, column_span_reg};
        acc_new  = acc_wrap ? (acc_sum - {1'b0, column_span_reg}) : acc_sum;
        row_step = step_quotient_reg + W'(acc_wrap);
        base_new = going_down_reg ? (row_base_reg - row_step) : (row_base_reg + row_step);
        target   = (going_down_reg && acc_new != '0) ? (base_new - 1'b1) : base_new;
        at_last  = col_inc == column_last_reg;
        adv_lo   = (row_previous_reg < target) ? row_previous_reg : target;
        adv_hi   = (row_previous_reg < target) ? target : row_previous_reg;
    end

    // divider start on a sloped load
    always_comb begin
        div_req.start    = accept && s_data.cmd == lsr_pkg::CMD_LOAD
                           && s_data.start_x != s_data.end_x;
        div_req.dividend = load_dy;
        div_req.divisor  = load_dx;
    end

    lsr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // request sequencer
    always_comb begin
        state_next          = state_reg;
        line_busy_next      = line_busy_reg;
        column_now_next     = column_now_reg;
        column_last_next    = column_last_reg;
        row_previous_next   = row_previous_reg;
        row_base_next       = row_base_reg;
        step_quotient_next  = step_quotient_reg;
        step_remainder_next = step_remainder_reg;
        error_acc_next      = error_acc_reg;
        column_span_next    = column_span_reg;
        going_down_next     = going_down_reg;
        held_color_next     = held_color_reg;
        span_next           = span_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_data_next         = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.cmd == lsr_pkg::CMD_LOAD) begin
                        held_color_next = s_data.line_color;
                        if (s_data.start_x == s_data.end_x) begin
                            // vertical line: one span, no walk
                            line_busy_next       = 1'b0;
                            column_now_next      = s_data.start_x;
                            column_last_next     = s_data.start_x;
                            span_next.column_x   = s_data.start_x;
                            span_next.span_low   = vert_lo;
                            span_next.span_high  = vert_hi;
                            span_next.span_color = s_data.line_color;
                            span_next.last_span  = 1'b1;
                            state_next           = ST_EMIT;
                        end else begin
                            line_busy_next       = 1'b1;
                            column_span_next     = load_dx;
                            going_down_next      = load_down;
                            error_acc_next       = '0;
                            row_base_next        = ord_y0;
                            row_previous_next    = ord_y0;
                            column_now_next      = ord_x0;
                            column_last_next     = ord_x1;
                            span_next.column_x   = ord_x0;
                            span_next.span_low   = ord_y0;
                            span_next.span_high  = ord_y0;
                            span_next.span_color = s_data.line_color;
                            span_next.last_span  = 1'b0;
                            state_next           = ST_DIVIDE;
                        end
                    end else if (line_busy_reg) begin
                        column_now_next      = col_inc;
                        error_acc_next       = acc_new;
                        row_base_next        = base_new;
                        row_previous_next    = target;
                        line_busy_next       = !at_last;
                        span_next.column_x   = col_inc;
                        span_next.span_low   = adv_lo;
                        span_next.span_high  = adv_hi;
                        span_next.span_color = held_color_reg;
                        span_next.last_span  = at_last;
                        state_next           = ST_EMIT;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    step_quotient_next  = div_rsp.quotient;
                    step_remainder_next = div_rsp.remainder;
                    state_next          = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = span_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            line_busy_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
            column_now_reg     <= '0;
            column_last_reg    <= '0;
            row_previous_reg   <= '0;
            row_base_reg       <= '0;
            step_quotient_reg  <= '0;
            step_remainder_reg <= '0;
            error_acc_reg      <= '0;
            column_span_reg    <= '0;
            going_down_reg     <= 1'b0;
            held_color_reg     <= '0;
        end else begin
            state_reg          <= state_next;
            line_busy_reg      <= line_busy_next;
            m_valid_reg        <= m_valid_next;
            column_now_reg     <= column_now_next;
            column_last_reg    <= column_last_next;
            row_previous_reg   <= row_previous_next;
            row_base_reg       <= row_base_next;
            step_quotient_reg  <= step_quotient_next;
            step_remainder_reg <= step_remainder_next;
            error_acc_reg      <= error_acc_next;
            column_span_reg    <= column_span_next;
            going_down_reg     <= going_down_next;
            held_color_reg     <= held_color_next;
        end
        span_reg   <= span_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
